@@ rtl/bps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Byte pattern scanner package
// Field widths, register indexes and parameter defaults of the scanner.
// ----------------------------------------------------------------------------
package bps_pkg;

    localparam int DATA_W    = 8;
    localparam int PATTERN_W = 64;
    localparam int SIZE_W    = 4;
    localparam int BASE_W    = 32;
    localparam int OFFSET_W  = 32;
    localparam int MADDR_W   = 32;
    localparam int COUNT_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = PATTERN_W;

    localparam int MAX_PATTERN_BYTES_DEF = 8;
    localparam int ADDRESS_BITS_DEF      = 32;

    localparam logic [SIZE_W-1:0] PATTERN_SIZE_RESET = SIZE_W'(4);

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_VALUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE   = 2'd2;

endpackage
`default_nettype wire

@@ rtl/byte_pattern_scanner.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Byte pattern scanner
// Finds non-overlapping little-endian occurrences of a configured value in a
// stream of memory bytes and reports their start address and running count.
// ----------------------------------------------------------------------------
// The scanner takes one byte word per clock cycle and runs at that rate
// without a stall as long as the result side keeps up. An accepted word is
// held in an input register and compared there combinationally against the
// pattern. A match is loaded into the output register once the input
// register passes its byte on, and the result word is presented from there.
// While a result word waits on the output side, the input register takes at
// most one more word and then holds off the sender. Configuration writes take
// effect at the next byte and are meant for idle periods.
module byte_pattern_scanner
#(
    parameter int MAX_PATTERN_BYTES = bps_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int ADDRESS_BITS      = bps_pkg::ADDRESS_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_we,
    input  wire logic [bps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bps_pkg::CFG_DATA_W-1:0] cfg_data,

    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire logic [bps_pkg::DATA_W-1:0]    data_byte,
    input  wire logic                          region_last,
    input  wire logic                          clear_count,

    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic [bps_pkg::MADDR_W-1:0]   match_address,
    output      logic [bps_pkg::COUNT_W-1:0]   match_total
);

    import bps_pkg::*;

    localparam int WIN_W   = DATA_W * MAX_PATTERN_BYTES;
    localparam int FILL_W  = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int SUP_W   = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int AW_EFF  = (ADDRESS_BITS < MADDR_W) ? ADDRESS_BITS : MADDR_W;
    localparam logic [MADDR_W:0] ADDR_MASK_WIDE =
        ((MADDR_W+1)'(1) << AW_EFF) - (MADDR_W+1)'(1);
    localparam logic [MADDR_W-1:0] ADDR_MASK = ADDR_MASK_WIDE[MADDR_W-1:0];
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PATTERN_BYTES);
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_PATTERN_BYTES);
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    logic [PATTERN_W-1:0] pattern_value_reg;
    logic [SIZE_W-1:0]    pattern_size_reg;
    logic [BASE_W-1:0]    region_base_reg;

    logic                 s1_valid_reg;
    logic [DATA_W-1:0]    s1_data_reg;
    logic                 s1_last_reg;
    logic                 s1_clear_reg;

    logic [WIN_W-1:0]     window_reg;
    logic [WIN_W-1:0]     window_next;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    logic [SUP_W-1:0]     suppress_reg;
    logic [SUP_W-1:0]     suppress_next;
    logic [OFFSET_W-1:0]  offset_reg;
    logic [OFFSET_W-1:0]  offset_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [MADDR_W-1:0]   match_address_reg;
    logic [COUNT_W-1:0]   match_total_reg;

    logic                 s1_advance;
    logic                 s1_fire;
    logic [SIZE_W-1:0]    size_eff;
    logic [WIN_W-1:0]     window_shift;
    logic [FILL_W-1:0]    fill_inc;
    logic [MAX_PATTERN_BYTES:1] size_equal;
    logic                 pattern_equal;
    logic                 hit;
    logic [COUNT_W-1:0]   count_base;
    logic [MADDR_W-1:0]   addr_sum;

    assign s1_advance = !out_valid_reg || out_ready;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign in_ready   = !s1_valid_reg || s1_advance;

    assign out_valid     = out_valid_reg;
    assign match_address = match_address_reg;
    assign match_total   = match_total_reg;

    always_comb
    begin
        if (pattern_size_reg == '0)
        begin
            size_eff = SIZE_W'(1);
        end
        else if (pattern_size_reg > SIZE_MAX)
        begin
            size_eff = SIZE_MAX;
        end
        else
        begin
            size_eff = pattern_size_reg;
        end
    end

    // The newest byte enters at the top of the window.
    assign window_shift = (window_reg >> DATA_W)
                        | (WIN_W'(s1_data_reg) << (DATA_W * (MAX_PATTERN_BYTES - 1)));
    assign fill_inc     = (fill_reg < FILL_MAX) ? fill_reg + FILL_W'(1) : fill_reg;

    always_comb
    begin
        for (int k = 1; k <= MAX_PATTERN_BYTES; k++)
        begin
            size_equal[k] = 1'b1;
            for (int j = 0; j < k; j++)
            begin
                if (window_shift[DATA_W*(MAX_PATTERN_BYTES-k+j) +: DATA_W]
                    != pattern_value_reg[DATA_W*j +: DATA_W])
                begin
                    size_equal[k] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        pattern_equal = 1'b0;
        for (int k = 1; k <= MAX_PATTERN_BYTES; k++)
        begin
            if (size_eff == SIZE_W'(k))
            begin
                pattern_equal = size_equal[k];
            end
        end
    end

    assign hit = (suppress_reg == '0) && (SIZE_W'(fill_inc) >= size_eff) && pattern_equal;

    assign count_base = s1_clear_reg ? '0 : count_reg;
    assign addr_sum   = region_base_reg + offset_reg - MADDR_W'(size_eff - SIZE_W'(1));

    always_comb
    begin
        window_next   = window_reg;
        fill_next     = fill_reg;
        suppress_next = suppress_reg;
        offset_next   = offset_reg;
        count_next    = count_reg;
        if (s1_fire)
        begin
            window_next = window_shift;
            fill_next   = fill_inc;
            count_next  = count_base;
            if (suppress_reg != '0)
            begin
                suppress_next = suppress_reg - SUP_W'(1);
            end
            else if (hit)
            begin
                suppress_next = SUP_W'(size_eff - SIZE_W'(1));
                if (count_base != COUNT_SAT)
                begin
                    count_next = count_base + COUNT_W'(1);
                end
            end
            if (s1_last_reg)
            begin
                window_next   = '0;
                fill_next     = '0;
                suppress_next = '0;
                offset_next   = '0;
            end
            else
            begin
                offset_next = offset_reg + OFFSET_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (s1_fire && hit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_value_reg <= '0;
            pattern_size_reg  <= PATTERN_SIZE_RESET;
            region_base_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERN_VALUE: pattern_value_reg <= cfg_data;
                CFG_PATTERN_SIZE:  pattern_size_reg  <= cfg_data[SIZE_W-1:0];
                CFG_REGION_BASE:   region_base_reg   <= cfg_data[BASE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            window_reg    <= '0;
            fill_reg      <= '0;
            suppress_reg  <= '0;
            offset_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            suppress_reg  <= suppress_next;
            offset_reg    <= offset_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg  <= data_byte;
            s1_last_reg  <= region_last;
            s1_clear_reg <= clear_count;
        end
        if (s1_fire && hit)
        begin
            match_address_reg <= addr_sum & ADDR_MASK;
            match_total_reg   <= count_next;
        end
    end

endmodule
`default_nettype wire
